[hdl/cfr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cfr_pkg;

  localparam logic [7:0] SYNC_FIRST         = 8'hAA;
  localparam logic [7:0] SYNC_SECOND        = 8'hAF;
  localparam logic [7:0] FUNC_LIMIT         = 8'hF1;
  localparam logic [7:0] ACK_ID             = 8'hEF;
  localparam logic [7:0] ACK_FUNC           = 8'h02;
  localparam logic [7:0] FUNC_GYRO          = 8'h01;
  localparam logic [7:0] FUNC_QUERY         = 8'h02;
  localparam logic [7:0] ARG_GYRO_CAL       = 8'h02;
  localparam logic [7:0] ARG_PARAM_READ     = 8'h01;
  localparam logic [7:0] ARG_VERSION        = 8'hA0;
  localparam logic [7:0] ARG_ACK            = 8'hA1;
  localparam logic [7:0] FUNC_ACK_LOW       = 8'h10;
  localparam logic [7:0] FUNC_ACK_HIGH      = 8'h15;
  localparam logic [7:0] LENGTH_LIMIT_RESET = 8'd50;

  // sum of the four fixed leading bytes of an acknowledge frame
  localparam logic [7:0] ACK_HEAD_SUM = 8'(SYNC_FIRST + SYNC_FIRST + ACK_ID + ACK_FUNC);

  localparam logic [2:0] ACK_BEATS = 3'd7;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_SYNC  = 3'd1,
    PH_FUNC  = 3'd2,
    PH_LEN   = 3'd3,
    PH_FIRST = 3'd4,
    PH_MORE  = 3'd5,
    PH_CHECK = 3'd6
  } cfr_phase_t;

  typedef struct packed {
    logic       is_ack;
    logic [7:0] func;
    logic [7:0] sum;
    logic       gyro;
    logic       param;
    logic       ver;
  } cfr_event_t;

endpackage

`default_nettype wire

[hdl/command_frame_receiver_unit.sv]
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    rx_byte
// out      output     out_valid / out_ready  ack_byte, ack_valid, gyro_cal_request,
//                                            param_read_request, version_request, last
// cfg      input      cfg_valid / cfg_ready  cfg_data (length_limit)
//
// one byte is taken per cycle while in_ready is high; the parser step is a single register-to-register pass
// a valid frame leaves one event in a one-entry slot; the emitter turns it into
// one result beat, or seven beats for an acknowledge frame, one beat per cycle while out_ready is high
// in_ready drops only while the event slot is full and the emitter is still busy
// synchronous reset returns the parser to idle and empties slot and output register
// cfg_ready is always high; length_limit resets to 50
`timescale 1ns / 1ps
`default_nettype none

module command_frame_receiver_unit import cfr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      ack_byte,
  output logic            ack_valid,
  output logic            gyro_cal_request,
  output logic            param_read_request,
  output logic            version_request,
  output logic            last,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data
);

  logic [7:0] length_limit;
  logic       in_accept;
  logic       ev_valid;
  cfr_event_t ev;
  logic       pend_valid;
  cfr_event_t pend;
  logic       emit_free;
  logic       pend_load;
  logic       advance;
  logic [2:0] idx;
  logic [7:0] emit_func;
  logic [7:0] emit_sum;
  logic [7:0] beat_byte;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      length_limit <= LENGTH_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      length_limit <= cfg_data;
    end
  end

  assign emit_free = !out_valid || (out_ready && last);
  assign pend_load = pend_valid && emit_free;
  assign in_ready  = !pend_valid || pend_load;
  assign in_accept = in_valid && in_ready;
  assign advance   = out_valid && out_ready && !last;

  cfr_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .step         (in_accept),
    .rx_byte      (rx_byte),
    .length_limit (length_limit),
    .ev_valid     (ev_valid),
    .ev           (ev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (in_accept && ev_valid) begin
      pend_valid <= 1'b1;
    end else if (pend_load) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && ev_valid) begin
      pend <= ev;
    end
  end

  // acknowledge byte for the beat that follows the one at idx
  always_comb begin
    case (idx)
      3'd1:    beat_byte = SYNC_FIRST;
      3'd2:    beat_byte = ACK_ID;
      3'd3:    beat_byte = ACK_FUNC;
      3'd4:    beat_byte = emit_func;
      3'd5:    beat_byte = emit_sum;
      3'd6:    beat_byte = 8'(ACK_HEAD_SUM + emit_func + emit_sum);
      default: beat_byte = SYNC_FIRST;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 3'd0;
    end else if (pend_load) begin
      out_valid <= 1'b1;
      idx       <= pend.is_ack ? 3'd1 : 3'd0;
    end else if (advance) begin
      idx <= 3'(idx + 3'd1);
    end else if (out_valid && out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_load) begin
      emit_func          <= pend.func;
      emit_sum           <= pend.sum;
      ack_valid          <= pend.is_ack;
      ack_byte           <= pend.is_ack ? SYNC_FIRST : 8'd0;
      gyro_cal_request   <= pend.is_ack ? 1'b0 : pend.gyro;
      param_read_request <= pend.is_ack ? 1'b0 : pend.param;
      version_request    <= pend.is_ack ? 1'b0 : pend.ver;
      last               <= !pend.is_ack;
    end else if (advance) begin
      ack_byte <= beat_byte;
      last     <= (idx == 3'(ACK_BEATS - 3'd1));
    end
  end

`ifndef NO_ASSERTIONS
  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid && ack_valid)
    else $error("acknowledge burst broken");

  a_last_at_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && ack_valid |-> (last == (idx == ACK_BEATS)))
    else $error("acknowledge last beat misplaced");

  a_flag_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ack_valid |-> last)
    else $error("request result not marked last");

  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({ack_valid, gyro_cal_request, param_read_request, version_request}))
    else $error("result mixes kinds");

  a_event_kept: assert property (@(posedge clk) disable iff (rst)
    pend_valid && !pend_load |=> pend_valid && $stable(pend))
    else $error("pending event lost");
`endif

endmodule

`default_nettype wire

[hdl/cfr_parser.sv]
`timescale 1ns / 1ps
`default_nettype none

module cfr_parser import cfr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] rx_byte,
  input  wire logic [7:0] length_limit,
  output logic            ev_valid,
  output cfr_event_t      ev
);

  cfr_phase_t phase, phase_next;
  logic [7:0] remaining_len, remaining_len_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] function_code, function_code_next;
  logic [7:0] first_payload, first_payload_next;
  logic [7:0] sum_plus;
  logic [7:0] rem_dec;

  assign sum_plus = 8'(running_sum + rx_byte);
  assign rem_dec  = 8'(remaining_len - 8'd1);

  always_comb begin
    phase_next         = phase;
    remaining_len_next = remaining_len;
    running_sum_next   = running_sum;
    function_code_next = function_code;
    first_payload_next = first_payload;
    if (step) begin
      case (phase)
        PH_IDLE: begin
          if (rx_byte == SYNC_FIRST) begin
            phase_next       = PH_SYNC;
            running_sum_next = rx_byte;
          end
        end
        PH_SYNC: begin
          if (rx_byte == SYNC_SECOND) begin
            phase_next       = PH_FUNC;
            running_sum_next = sum_plus;
          end else begin
            phase_next = PH_IDLE;
          end
        end
        PH_FUNC: begin
          if (rx_byte < FUNC_LIMIT) begin
            phase_next         = PH_LEN;
            function_code_next = rx_byte;
            running_sum_next   = sum_plus;
          end else begin
            phase_next = PH_IDLE;
          end
        end
        PH_LEN: begin
          if (rx_byte < length_limit) begin
            phase_next         = PH_FIRST;
            remaining_len_next = rx_byte;
            running_sum_next   = sum_plus;
          end else begin
            phase_next = PH_IDLE;
          end
        end
        PH_FIRST, PH_MORE: begin
          if (remaining_len == 8'd0) begin
            phase_next = PH_IDLE;
          end else begin
            if (phase == PH_FIRST) begin
              first_payload_next = rx_byte;
            end
            remaining_len_next = rem_dec;
            running_sum_next   = sum_plus;
            phase_next         = (rem_dec == 8'd0) ? PH_CHECK : PH_MORE;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    ev_valid  = step && (phase == PH_CHECK) && (rx_byte == running_sum);
    ev.func   = function_code;
    ev.sum    = running_sum;
    ev.is_ack = ((function_code == FUNC_QUERY) && (first_payload == ARG_ACK)) ||
                ((function_code >= FUNC_ACK_LOW) && (function_code <= FUNC_ACK_HIGH));
    ev.gyro   = (function_code == FUNC_GYRO) && (first_payload == ARG_GYRO_CAL);
    ev.param  = (function_code == FUNC_QUERY) && (first_payload == ARG_PARAM_READ);
    ev.ver    = (function_code == FUNC_QUERY) && (first_payload == ARG_VERSION);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      remaining_len <= 8'd0;
      running_sum   <= 8'd0;
      function_code <= 8'd0;
      first_payload <= 8'd0;
    end else begin
      phase         <= phase_next;
      remaining_len <= remaining_len_next;
      running_sum   <= running_sum_next;
      function_code <= function_code_next;
      first_payload <= first_payload_next;
    end
  end

endmodule

`default_nettype wire
